// ===== rtl/lsp_pkg.sv =====
// Package for the LED status pattern generator: event codes, controller states,
// divider status type and the narrow percent helpers. No dependencies.
`timescale 1ns / 1ps

package lsp_pkg;

	typedef enum logic [2:0] {
		FN_INIT        = 3'd0,
		FN_PROGRESS    = 3'd1,
		FN_READY       = 3'd2,
		FN_ERROR       = 3'd3,
		FN_PAUSED      = 3'd4,
		FN_OFF         = 3'd5,
		FN_SEND_FAILED = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	localparam int QUO_W = 7;
	localparam int DIV_STEPS = QUO_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [QUO_W-1:0] PCT_FULL    = 7'd100;
	localparam logic [4:0]       STEP_NONE   = 5'd31;
	localparam logic [7:0]       BYTE_FULL   = 8'hFF;
	localparam logic [7:0]       DELAY_BLINK = 8'h20;
	localparam logic [7:0]       RED_PAUSE   = 8'h80;
	localparam int               BLINK_BIT   = 2;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] pct;
	} div_stat_t;

	// percent / 5 for percent up to 100
	function automatic logic [4:0] step_of(input logic [QUO_W-1:0] pct);
		logic [14:0] p;
		p = 15'(pct) * 15'd205;
		return p[14:10];
	endfunction

	// percent * 255 / 100 for percent up to 100
	function automatic logic [7:0] green_of(input logic [QUO_W-1:0] pct);
		logic [14:0] v;
		logic [27:0] m;
		v = {pct, 8'b0} - 15'(pct);
		m = 28'(v) * 28'd5243;
		return m[26:19];
	endfunction

endpackage

// ===== rtl/lsp_if.sv =====
// Handshake channels of the LED status pattern generator: status event words in,
// pattern slot words out. Depends on nothing.
`timescale 1ns / 1ps

interface lsp_evt_if #(parameter int COUNT_WIDTH = 48);
	logic                   valid;
	logic                   ready;
	logic [2:0]             func;
	logic [COUNT_WIDTH-1:0] done_req;
	logic [COUNT_WIDTH-1:0] total;

	modport source(output valid, func, done_req, total, input ready);
	modport sink(input valid, func, done_req, total, output ready);
endinterface

interface lsp_pat_if;
	logic       valid;
	logic       ready;
	logic [4:0] slot;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] step_delay;
	logic [7:0] smoothing;
	logic [7:0] loop_hold;
	logic       last;

	modport source(output valid, slot, red, green, blue, step_delay, smoothing,
		loop_hold, last, input ready);
	modport sink(input valid, slot, red, green, blue, step_delay, smoothing,
		loop_hold, last, output ready);
endinterface

// ===== rtl/lsp_div.sv =====
// Percent divider: one quotient bit per cycle of done*100 / total, saturated to 100.
// Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_div #(
	parameter int COUNT_WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [COUNT_WIDTH+6:0]   dividend,
	input  logic [COUNT_WIDTH-1:0]   divisor,
	output lsp_pkg::div_stat_t       stat
);
	import lsp_pkg::*;

	localparam int NW = COUNT_WIDTH + QUO_W;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NW-1:0]        rem_q;
	logic [NW-1:0]        den_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 sat_q;
	logic                 zero_q;
	logic                 ge;

	assign ge = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the divisor down one place per step, trial subtract
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			den_q  <= {divisor, {QUO_W{1'b0}}};
			quo_q  <= '0;
			sat_q  <= 1'b0;
			zero_q <= (divisor == '0);
		end else if (run_q) begin
			if (ge)
				rem_q <= rem_q - den_q;
			den_q <= den_q >> 1;
			if (cnt_q == '0)
				sat_q <= ge;
			else
				quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	always_comb begin
		stat.done = done_q;
		if (zero_q)
			stat.pct = '0;
		else if (sat_q || (quo_q > PCT_FULL))
			stat.pct = PCT_FULL;
		else
			stat.pct = quo_q;
	end

endmodule

// ===== rtl/led_status_pattern_generator_unit.sv =====
// LED status pattern generator top level: event decode, percent bookkeeping and
// slot emission. Depends on lsp_pkg, lsp_if and lsp_div.
// Slot 0 is offered in the cycle after acceptance; a progress event first divides, hands over and checks.
// One event at a time; an emitting event holds the input until its final slot is taken,
// one slot word per cycle while the sink takes it.
// Reset: step memory to none, failure flag cleared, no word pending.
`timescale 1ns / 1ps

module led_status_pattern_generator_unit #(
	parameter int PATTERN_LEN = 32,
	parameter int COUNT_WIDTH = 48
) (
	input logic       clk,
	input logic       arst_n,
	lsp_evt_if.sink   evt,
	lsp_pat_if.source pat
);
	import lsp_pkg::*;

	localparam int NW    = COUNT_WIDTH + QUO_W;
	localparam int CNT_W = $clog2(PATTERN_LEN);

	state_t           state_q, state_d;
	logic [4:0]       last_q;
	logic             failed_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       red_q, green_q, blue_q;
	logic             blink_q, solid_q;
	logic [QUO_W-1:0] pct_q;

	func_t            fn;
	logic             take;
	logic             slot_done;
	logic             div_start;
	logic [NW-1:0]    dividend;
	logic [4:0]       step;
	logic [7:0]       green_val;
	logic             lit;
	div_stat_t        div_stat;

	assign fn        = func_t'(evt.func);
	assign take      = evt.valid && evt.ready;
	assign slot_done = pat.valid && pat.ready;
	assign dividend  = (NW'(evt.done_req) << 6) + (NW'(evt.done_req) << 5)
		+ (NW'(evt.done_req) << 2);
	assign step      = step_of(pct_q);
	assign green_val = green_of(pct_q);

	lsp_div #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (evt.total),
		.stat     (div_stat)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt.valid) begin
					unique case (fn) inside
						FN_INIT:     state_d = ST_EMIT;
						FN_PROGRESS: state_d = ST_DIV;
						FN_READY, FN_ERROR, FN_PAUSED, FN_OFF:
							state_d = failed_q ? ST_IDLE : ST_EMIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (div_stat.done)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (step == last_q || failed_q)
					state_d = ST_IDLE;
				else
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_done && pat.last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		evt.ready = (state_q == ST_IDLE);
		pat.valid = (state_q == ST_EMIT);
		div_start = (state_q == ST_IDLE) && evt.valid && (fn == FN_PROGRESS);
	end

	assign lit            = !blink_q || !cnt_q[BLINK_BIT];
	assign pat.slot       = 5'(cnt_q);
	assign pat.red        = lit ? red_q : '0;
	assign pat.green      = lit ? green_q : '0;
	assign pat.blue       = lit ? blue_q : '0;
	assign pat.step_delay = blink_q ? DELAY_BLINK : '0;
	assign pat.smoothing  = solid_q ? BYTE_FULL : '0;
	assign pat.loop_hold  = blink_q ? BYTE_FULL : '0;
	assign pat.last       = (cnt_q == CNT_W'(PATTERN_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			last_q   <= STEP_NONE;
			failed_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != ST_EMIT)
				cnt_q <= '0;
			else if (slot_done)
				cnt_q <= cnt_q + 1'b1;
			if (take) begin
				unique case (fn) inside
					FN_INIT: begin
						failed_q <= 1'b0;
						last_q   <= STEP_NONE;
					end
					FN_READY, FN_ERROR, FN_PAUSED: last_q <= STEP_NONE;
					FN_SEND_FAILED:                failed_q <= 1'b1;
					default: ;
				endcase
			end
			if (state_q == ST_DECIDE && step != last_q)
				last_q <= step;
		end
	end

	// pattern colours and animation kind
	always_ff @(posedge clk) begin
		if (div_stat.done)
			pct_q <= div_stat.pct;
		if (take) begin
			case (fn)
				FN_READY: begin
					{red_q, green_q, blue_q} <= {8'h00, BYTE_FULL, 8'h00};
					{blink_q, solid_q}       <= 2'b10;
				end
				FN_ERROR: begin
					{red_q, green_q, blue_q} <= {BYTE_FULL, 8'h00, 8'h00};
					{blink_q, solid_q}       <= 2'b10;
				end
				FN_PAUSED: begin
					{red_q, green_q, blue_q} <= {RED_PAUSE, 8'h00, BYTE_FULL};
					{blink_q, solid_q}       <= 2'b01;
				end
				default: begin
					{red_q, green_q, blue_q} <= '0;
					{blink_q, solid_q}       <= 2'b00;
				end
			endcase
		end else if (state_q == ST_DECIDE) begin
			{red_q, green_q, blue_q} <= {8'h00, green_val, ~green_val};
			{blink_q, solid_q}       <= 2'b01;
		end
	end

	a_idle_when_accept: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !pat.valid)
		else $error("event word taken while a pattern is out");

	a_pattern_ends: assert property (@(posedge clk) disable iff (!arst_n)
		slot_done && pat.last |=> !pat.valid)
		else $error("slot words continue past the final slot");

	a_no_output_failed: assert property (@(posedge clk) disable iff (!arst_n)
		pat.valid |-> !failed_q)
		else $error("pattern emitted while failure latched");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q <= 5'd20) || (last_q == STEP_NONE))
		else $error("step memory holds an impossible step");

endmodule
